[hw/rtl/seven_segment_serial_display_driver_core_macros.svh]
// assertion helpers shared by the display driver modules
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssdd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SSDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssdd assertion failed");

`endif

[hw/rtl/ssdd_pkg.sv]
`default_nettype none

package ssdd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int BYTE_W      = $clog2(DIGIT_COUNT + 1);

    // queue depth must be a power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h88;
    localparam logic [7:0] SEG_POINT = 8'h80;

    localparam logic [1:0] FRAME_ABORT = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS   = 2'd0,
        CFG_REFRESH      = 2'd1,
        CFG_BLINK_HALF   = 2'd2,
        CFG_ACK_WAIT     = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_HI = 4'd1,
        PH_START_LO = 4'd2,
        PH_BIT_LO   = 4'd3,
        PH_BIT_HI   = 4'd4,
        PH_ACK_WAIT = 4'd5,
        PH_ACK_HI   = 4'd6,
        PH_ACK_LO   = 4'd7,
        PH_STOP_A   = 4'd8,
        PH_STOP_B   = 4'd9,
        PH_STOP_C   = 4'd10
    } t_phase;

    typedef logic [DIGIT_COUNT-1:0][7:0] t_codes;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               editing;
        logic [1:0]         edit_position;
        logic [2:0]         point_position;
        logic               dio_sample;
    } t_item;

    typedef struct packed {
        t_codes             codes;
        logic [VALUE_W-1:0] value;
        logic               editing;
        logic [1:0]         edit_position;
        logic               dio_sample;
    } t_job;

    typedef struct packed {
        logic [2:0]  brightness;
        logic [15:0] refresh_interval;
        logic [19:0] blink_half_period;
        logic [7:0]  ack_wait;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam t_cfg CFG_RESET = '{
        brightness:        3'd7,
        refresh_interval:  16'd2000,
        blink_half_period: 20'd100000,
        ack_wait:          8'd60
    };

    function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'h3F;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5B;
            4'd3: seg = 8'h4F;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6D;
            4'd6: seg = 8'h7D;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7F;
            4'd9: seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/seven_segment_serial_display_driver_core.sv]
// channel   direction  handshake                 payload
// in        to core    i_in_valid / o_in_stall   shown_value, editing, edit_position,
//                                                point_position, dio_sample
// out       from core  o_out_valid / i_out_stall clk_level, dio_level, dio_drive,
//                                                busy_res, ack_fault
// cfg       to core    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one tick per cycle unless the output stalls; the back end registers each bus step
// a tick passes the divide-by-ten stages (the first loaded at the transfer edge), then a
// queue entry, then the bus step that loads the result register
// synchronous active-low reset clears control state and restores register defaults
// output stall fills the four-entry queue, then holds the digit pipeline and input
`default_nettype none

module seven_segment_serial_display_driver_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ssdd_pkg::VALUE_W-1:0]    i_shown_value,
    input  wire logic                            i_editing,
    input  wire logic [1:0]                      i_edit_position,
    input  wire logic [2:0]                      i_point_position,
    input  wire logic                            i_dio_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_clk_level,
    output logic                                 o_dio_level,
    output logic                                 o_dio_drive,
    output logic                                 o_busy_res,
    output logic                                 o_ack_fault,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ssdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssdd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ssdd_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_job    front_job;
    t_job    head_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BRIGHTNESS: r_cfg.brightness        <= i_cfg_data[2:0];
                CFG_REFRESH:    r_cfg.refresh_interval  <= i_cfg_data[15:0];
                CFG_BLINK_HALF: r_cfg.blink_half_period <= i_cfg_data[19:0];
                CFG_ACK_WAIT:   r_cfg.ack_wait          <= i_cfg_data[7:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign item.value          = i_shown_value;
    assign item.editing        = i_editing;
    assign item.edit_position  = i_edit_position;
    assign item.point_position = i_point_position;
    assign item.dio_sample     = i_dio_sample;

    ssdd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (item),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (front_job)
    );

    ssdd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (front_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_stat     (q_stat)
    );

    ssdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .i_job       (head_job),
        .o_job_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_clk_level (o_clk_level),
        .o_dio_level (o_dio_level),
        .o_dio_drive (o_dio_drive),
        .o_busy_res  (o_busy_res),
        .o_ack_fault (o_ack_fault)
    );

endmodule

`default_nettype wire

[hw/rtl/ssdd_front.sv]
`default_nettype none

module ssdd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ssdd_pkg::t_item i_item,
    input  wire ssdd_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output ssdd_pkg::t_job       o_job
);
    import ssdd_pkg::*;

    // one stage per decimal digit, units first
    logic               r_vld   [DIGIT_COUNT];
    t_item              r_item  [DIGIT_COUNT];
    logic [VALUE_W-1:0] r_rem   [DIGIT_COUNT];
    t_codes             r_codes [DIGIT_COUNT];
    logic               hold;

    assign hold       = r_vld[DIGIT_COUNT-1] & i_q_stat.full;
    assign o_in_stall = hold;
    assign o_push     = r_vld[DIGIT_COUNT-1] & ~i_q_stat.full;

    for (genvar s = 0; s < DIGIT_COUNT; s++) begin : g_stage
        logic               vld_in;
        t_item              item_in;
        logic [VALUE_W-1:0] rem_in;
        t_codes             codes_in;
        logic [31:0]        prod;
        logic [VALUE_W-1:0] quo;
        logic [3:0]         digit;

        if (s == 0) begin : g_first
            assign vld_in   = i_in_valid;
            assign item_in  = i_item;
            assign rem_in   = i_item.value;
            assign codes_in = '0;
        end else begin : g_next
            assign vld_in   = r_vld[s-1];
            assign item_in  = r_item[s-1];
            assign rem_in   = r_rem[s-1];
            assign codes_in = r_codes[s-1];
        end

        assign prod  = 32'(rem_in) * DIV10_MUL;
        assign quo   = VALUE_W'(prod >> DIV10_SHIFT);
        assign digit = 4'(rem_in - VALUE_W'(quo * 16'd10));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (!hold) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!hold) begin
                r_item[s] <= item_in;
                r_rem[s]  <= quo;
                for (int j = 0; j < DIGIT_COUNT; j++) begin
                    if (j == DIGIT_COUNT - 1 - s) begin
                        r_codes[s][j] <= seg_of_digit(digit);
                    end else begin
                        r_codes[s][j] <= codes_in[j];
                    end
                end
            end
        end
    end

    // decimal point goes on at the exit of the digit pipeline
    always_comb begin
        o_job.value         = r_item[DIGIT_COUNT-1].value;
        o_job.editing       = r_item[DIGIT_COUNT-1].editing;
        o_job.edit_position = r_item[DIGIT_COUNT-1].edit_position;
        o_job.dio_sample    = r_item[DIGIT_COUNT-1].dio_sample;
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            if (32'(r_item[DIGIT_COUNT-1].point_position) == j) begin
                o_job.codes[j] = r_codes[DIGIT_COUNT-1][j] | SEG_POINT;
            end else begin
                o_job.codes[j] = r_codes[DIGIT_COUNT-1][j];
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ssdd_queue.sv]
`default_nettype none
`include "seven_segment_serial_display_driver_core_macros.svh"

module ssdd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ssdd_pkg::t_job    i_push_job,
    input  wire logic              i_pop,
    output ssdd_pkg::t_job         o_head,
    output ssdd_pkg::t_q_stat      o_stat
);
    import ssdd_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_stat.full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW + 1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    `SSDD_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, o_stat.full, !i_push)
    `SSDD_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, o_stat.empty, !i_pop)
    `SSDD_ASSERT_NOW(a_full_not_empty, i_clk, i_rst_n, o_stat.full, !o_stat.empty)

endmodule

`default_nettype wire

[hw/rtl/ssdd_back.sv]
`default_nettype none
`include "seven_segment_serial_display_driver_core_macros.svh"

module ssdd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssdd_pkg::t_cfg    i_cfg,
    input  wire ssdd_pkg::t_q_stat i_q_stat,
    input  wire ssdd_pkg::t_job    i_job,
    output logic                   o_job_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_clk_level,
    output logic                   o_dio_level,
    output logic                   o_dio_drive,
    output logic                   o_busy_res,
    output logic                   o_ack_fault
);
    import ssdd_pkg::*;

    logic [19:0]        r_blink_cnt,  n_blink_cnt;
    logic               r_blink_on,   n_blink_on;
    logic [15:0]        r_ref_cnt,    n_ref_cnt;
    logic               r_first,      n_first;
    logic [VALUE_W-1:0] r_prev_value, n_prev_value;
    logic [1:0]         r_prev_epos,  n_prev_epos;
    logic               r_prev_edit,  n_prev_edit;
    t_codes             r_codes,      n_codes;
    t_phase             r_phase,      n_phase;
    logic [1:0]         r_frame_num,  n_frame_num;
    logic [BYTE_W-1:0]  r_byte_num,   n_byte_num;
    logic [2:0]         r_bit_num,    n_bit_num;
    logic [7:0]         r_shift,      n_shift;
    logic [7:0]         r_ack_cnt,    n_ack_cnt;
    logic               n_fault;

    logic r_out_valid, r_out_clk, r_out_dio, r_out_drv, r_out_busy, r_out_fault;
    logic n_clk, n_dio, n_drv, n_busy;

    logic [7:0] code_sel;
    logic       blank;
    logic       changed;

    assign o_job_pop = ~i_q_stat.empty & (~r_out_valid | ~i_out_stall);

    always_comb begin
        code_sel = 8'h00;
        for (int j = 0; j < DIGIT_COUNT; j++) begin
            if (32'(r_byte_num) == j) begin
                code_sel = r_codes[j];
            end
        end
    end

    assign changed = r_first || (i_job.value != r_prev_value) ||
                     (i_job.edit_position != r_prev_epos) ||
                     (i_job.editing != r_prev_edit) || i_job.editing;

    // next state for one bus tick
    always_comb begin
        n_blink_cnt  = r_blink_cnt + 20'd1;
        n_blink_on   = r_blink_on;
        n_ref_cnt    = r_ref_cnt;
        n_first      = r_first;
        n_prev_value = r_prev_value;
        n_prev_epos  = r_prev_epos;
        n_prev_edit  = r_prev_edit;
        n_codes      = r_codes;
        n_phase      = r_phase;
        n_frame_num  = r_frame_num;
        n_byte_num   = r_byte_num;
        n_bit_num    = r_bit_num;
        n_shift      = r_shift;
        n_ack_cnt    = r_ack_cnt;
        n_fault      = 1'b0;

        if (n_blink_cnt >= i_cfg.blink_half_period) begin
            n_blink_cnt = 20'd0;
            n_blink_on  = ~r_blink_on;
        end
        blank = i_job.editing & n_blink_on;

        if (r_ref_cnt < i_cfg.refresh_interval) begin
            n_ref_cnt = r_ref_cnt + 16'd1;
        end

        if (r_phase == PH_IDLE) begin
            if (n_ref_cnt >= i_cfg.refresh_interval) begin
                n_ref_cnt = 16'd0;
                if (changed) begin
                    n_first      = 1'b0;
                    n_prev_value = i_job.value;
                    n_prev_epos  = i_job.edit_position;
                    n_prev_edit  = i_job.editing;
                    for (int j = 0; j < DIGIT_COUNT; j++) begin
                        if (blank && (32'(i_job.edit_position) == j)) begin
                            n_codes[j] = 8'h00;
                        end else begin
                            n_codes[j] = i_job.codes[j];
                        end
                    end
                    n_frame_num = 2'd0;
                    n_byte_num  = '0;
                    n_shift     = CMD_DATA;
                    n_bit_num   = 3'd0;
                    n_phase     = PH_START_HI;
                end
            end
        end else begin
            case (r_phase)
                PH_START_HI: n_phase = PH_START_LO;
                PH_START_LO: n_phase = PH_BIT_LO;
                PH_BIT_LO:   n_phase = PH_BIT_HI;
                PH_BIT_HI: begin
                    if (r_bit_num == 3'd7) begin
                        n_ack_cnt = 8'd0;
                        n_phase   = PH_ACK_WAIT;
                    end else begin
                        n_bit_num = r_bit_num + 3'd1;
                        n_shift   = r_shift >> 1;
                        n_phase   = PH_BIT_LO;
                    end
                end
                PH_ACK_WAIT: begin
                    if (!i_job.dio_sample) begin
                        n_phase = PH_ACK_HI;
                    end else begin
                        if (r_ack_cnt != 8'hFF) begin
                            n_ack_cnt = r_ack_cnt + 8'd1;
                        end
                        if (n_ack_cnt >= i_cfg.ack_wait) begin
                            n_fault     = 1'b1;
                            n_frame_num = FRAME_ABORT;
                            n_phase     = PH_ACK_HI;
                        end
                    end
                end
                PH_ACK_HI: n_phase = PH_ACK_LO;
                PH_ACK_LO: begin
                    if ((r_frame_num == 2'd1) && (r_byte_num < BYTE_W'(DIGIT_COUNT))) begin
                        n_shift    = code_sel;
                        n_bit_num  = 3'd0;
                        n_byte_num = r_byte_num + BYTE_W'(1);
                        n_phase    = PH_BIT_LO;
                    end else begin
                        n_phase = PH_STOP_A;
                    end
                end
                PH_STOP_A: n_phase = PH_STOP_B;
                PH_STOP_B: n_phase = PH_STOP_C;
                PH_STOP_C: begin
                    if (r_frame_num >= 2'd2) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_frame_num = r_frame_num + 2'd1;
                        n_bit_num   = 3'd0;
                        if (n_frame_num == 2'd1) begin
                            n_shift    = CMD_ADDR;
                            n_byte_num = '0;
                        end else begin
                            n_shift = CMD_CTRL | {5'b0, i_cfg.brightness};
                        end
                        n_phase = PH_START_HI;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // pin levels for the phase entered on this tick
    always_comb begin
        case (n_phase)
            PH_START_LO: begin n_clk = 1'b1; n_dio = 1'b0;       n_drv = 1'b1; end
            PH_BIT_LO:   begin n_clk = 1'b0; n_dio = n_shift[0]; n_drv = 1'b1; end
            PH_BIT_HI:   begin n_clk = 1'b1; n_dio = n_shift[0]; n_drv = 1'b1; end
            PH_ACK_WAIT: begin n_clk = 1'b0; n_dio = 1'b0;       n_drv = 1'b0; end
            PH_ACK_HI:   begin n_clk = 1'b1; n_dio = 1'b0;       n_drv = 1'b0; end
            PH_ACK_LO:   begin n_clk = 1'b0; n_dio = 1'b0;       n_drv = 1'b1; end
            PH_STOP_A:   begin n_clk = 1'b0; n_dio = 1'b0;       n_drv = 1'b1; end
            PH_STOP_B:   begin n_clk = 1'b1; n_dio = 1'b0;       n_drv = 1'b1; end
            default:     begin n_clk = 1'b1; n_dio = 1'b1;       n_drv = 1'b1; end
        endcase
        n_busy = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_cnt  <= 20'd0;
            r_blink_on   <= 1'b0;
            r_ref_cnt    <= 16'd0;
            r_first      <= 1'b1;
            r_prev_value <= '1;
            r_prev_epos  <= 2'd0;
            r_prev_edit  <= 1'b0;
            r_phase      <= PH_IDLE;
            r_frame_num  <= 2'd0;
            r_byte_num   <= '0;
            r_bit_num    <= 3'd0;
            r_shift      <= 8'd0;
            r_ack_cnt    <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_blink_cnt  <= n_blink_cnt;
                r_blink_on   <= n_blink_on;
                r_ref_cnt    <= n_ref_cnt;
                r_first      <= n_first;
                r_prev_value <= n_prev_value;
                r_prev_epos  <= n_prev_epos;
                r_prev_edit  <= n_prev_edit;
                r_phase      <= n_phase;
                r_frame_num  <= n_frame_num;
                r_byte_num   <= n_byte_num;
                r_bit_num    <= n_bit_num;
                r_shift      <= n_shift;
                r_ack_cnt    <= n_ack_cnt;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_codes     <= n_codes;
            r_out_clk   <= n_clk;
            r_out_dio   <= n_dio;
            r_out_drv   <= n_drv;
            r_out_busy  <= n_busy;
            r_out_fault <= n_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clk_level = r_out_clk;
    assign o_dio_level = r_out_dio;
    assign o_dio_drive = r_out_drv;
    assign o_busy_res  = r_out_busy;
    assign o_ack_fault = r_out_fault;

    `SSDD_ASSERT_NOW(a_fault_only_in_ack, i_clk, i_rst_n, o_job_pop && n_fault, r_phase == PH_ACK_WAIT)
    `SSDD_ASSERT_NEXT(a_pop_fills_result, i_clk, i_rst_n, o_job_pop, r_out_valid)
    `SSDD_ASSERT_NOW(a_frame_starts_clean, i_clk, i_rst_n, r_phase == PH_START_HI, r_bit_num == 3'd0)

endmodule

`default_nettype wire
